FILE: hw/rtl/cave_pkg.sv
// Shared types and constants for the cave cellular automaton step core.
// No dependencies; imported by every module of the block.
`default_nettype none
package cave_pkg;

    localparam int MAX_COLS_DEF = 62;
    localparam int MAX_ROWS_DEF = 62;

    // configuration register widths and indexes
    localparam int CFG_SIZE_W = 6;
    localparam int CFG_THR_W  = 4;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_KEEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_TO_WALL = 2'd3;

    localparam logic [CFG_SIZE_W-1:0] GRID_COLS_RST     = 6'd32;
    localparam logic [CFG_SIZE_W-1:0] GRID_ROWS_RST     = 6'd16;
    localparam logic [CFG_THR_W-1:0]  WALL_KEEP_RST     = 4'd3;
    localparam logic [CFG_THR_W-1:0]  FLOOR_TO_WALL_RST = 4'd6;
    localparam logic [CFG_SIZE_W-1:0] MIN_SIZE          = 6'd3;

    // op queue between front and back
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

    // one classified input word: the cell result, plus whether a border
    // wall follows (row end) and whether the last-row flush follows
    typedef struct packed {
        logic next_bit;
        logic border;
        logic flush;
    } t_op;

endpackage
`default_nettype wire

FILE: hw/rtl/cave_cellular_automaton_step_core.sv
// One generation of a cave-building cellular automaton over a raster cell
// stream (0 wall, 1 floor). Cells are taken one per cycle; each cell after the
// first row and column yields the result one row and one column behind it, a
// row's last cell yields two (the extra one a border wall), and the grid's
// final cell yields grid_cols + 2, so a grid yields rows*cols result words,
// at one word per cycle from the output register while pop is high. The input
// side is held off by a four-entry op queue when results back up, and after reset
// or after a size change while the line-store read for the new column is
// refetched. Sizes are clamped to 3..MAX_COLS and 3..MAX_ROWS.
// Depends on cave_pkg, cave_front, cave_opq and cave_back.
`default_nettype none
module cave_cellular_automaton_step_core
    import cave_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_cell_in,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       o_cell_out,
    output logic                       o_last_of_run,
    output logic                       o_last_of_grid
);

    localparam logic [CFG_SIZE_W-1:0] MAXC = CFG_SIZE_W'(MAX_COLS);
    localparam logic [CFG_SIZE_W-1:0] MAXR = CFG_SIZE_W'(MAX_ROWS);

    logic [CFG_SIZE_W-1:0] r_grid_cols;
    logic [CFG_SIZE_W-1:0] r_grid_rows;
    logic [CFG_THR_W-1:0]  r_wall_keep_min;
    logic [CFG_THR_W-1:0]  r_floor_to_wall_min;

    logic [CFG_SIZE_W-1:0] cols;
    logic [CFG_SIZE_W-1:0] rows;

    logic op_push;
    t_op  op_in;
    logic op_full;
    logic op_pop;
    t_op  op_head;
    logic op_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols         <= GRID_COLS_RST;
            r_grid_rows         <= GRID_ROWS_RST;
            r_wall_keep_min     <= WALL_KEEP_RST;
            r_floor_to_wall_min <= FLOOR_TO_WALL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_COLS:     r_grid_cols         <= i_cfg_data;
                CFG_GRID_ROWS:     r_grid_rows         <= i_cfg_data;
                CFG_WALL_KEEP:     r_wall_keep_min     <= i_cfg_data[CFG_THR_W-1:0];
                CFG_FLOOR_TO_WALL: r_floor_to_wall_min <= i_cfg_data[CFG_THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_cols < MIN_SIZE)  cols = MIN_SIZE;
        else if (r_grid_cols > MAXC) cols = MAXC;
        else                         cols = r_grid_cols;
        if (r_grid_rows < MIN_SIZE)  rows = MIN_SIZE;
        else if (r_grid_rows > MAXR) rows = MAXR;
        else                         rows = r_grid_rows;
    end

    cave_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cols              (cols),
        .i_rows              (rows),
        .i_wall_keep_min     (r_wall_keep_min),
        .i_floor_to_wall_min (r_floor_to_wall_min),
        .i_push              (push),
        .i_cell_in           (i_cell_in),
        .o_full              (full),
        .o_op_push           (op_push),
        .o_op                (op_in),
        .i_op_full           (op_full)
    );

    cave_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_op    (op_head),
        .o_empty (op_empty)
    );

    cave_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cols         (cols),
        .i_op           (op_head),
        .i_op_empty     (op_empty),
        .o_op_pop       (op_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_cell_out     (o_cell_out),
        .o_last_of_run  (o_last_of_run),
        .o_last_of_grid (o_last_of_grid)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/cave_front.sv
// Front end: position tracking, line stores, 3x3 window and the cell rule.
// Classifies each accepted word outside the first row and column into a t_op. Depends on cave_pkg.
`default_nettype none
module cave_front
    import cave_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [CFG_SIZE_W-1:0] i_cols,
    input  wire logic [CFG_SIZE_W-1:0] i_rows,
    input  wire logic [CFG_THR_W-1:0]  i_wall_keep_min,
    input  wire logic [CFG_THR_W-1:0]  i_floor_to_wall_min,
    input  wire logic                  i_push,
    input  wire logic                  i_cell_in,
    output logic                       o_full,
    output logic                       o_op_push,
    output t_op                        o_op,
    input  wire logic                  i_op_full
);

    localparam int AW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [8:0]    r_window;

    // line store: bit 1 middle row, bit 0 upper row
    logic [1:0]    mem [MAX_COLS];
    logic [1:0]    r_rd;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_valid;

    logic                  restart;
    logic [AW-1:0]         c;
    logic [RW-1:0]         r;
    logic [CFG_SIZE_W-1:0] c_ext;
    logic [CFG_SIZE_W-1:0] r_ext;
    logic                  last_col;
    logic                  last_row;
    logic                  rd_ok;
    logic                  accept;
    logic [2:0]            col_bits;
    logic [8:0]            n_window;
    logic [3:0]            walls;
    logic                  rule_cell;
    logic [AW-1:0]         n_col;
    logic [RW-1:0]         n_row;
    logic [AW-1:0]         rd_addr;

    always_comb begin
        restart  = ((CFG_SIZE_W'(r_col)) >= i_cols) || ((CFG_SIZE_W'(r_row)) >= i_rows);
        c        = restart ? '0 : r_col;
        r        = restart ? '0 : r_row;
        c_ext    = CFG_SIZE_W'(c);
        r_ext    = CFG_SIZE_W'(r);
        last_col = (c_ext == i_cols - 1'b1);
        last_row = (r_ext == i_rows - 1'b1);
    end

    // read data is only good when it was fetched for the current column
    assign rd_ok  = r_rd_valid && (r_rd_addr == c);
    assign o_full = !rd_ok || i_op_full;
    assign accept = i_push && !o_full;

    always_comb begin
        col_bits = {i_cell_in, r_rd[1], r_rd[0]};
        n_window = {col_bits, r_window[8:3]};
        walls    = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4 && !n_window[i]) walls = walls + 4'd1;
        end
        if (!n_window[4]) rule_cell = !(walls >= i_wall_keep_min);
        else              rule_cell = !(walls >= i_floor_to_wall_min);
    end

    always_comb begin
        n_col   = last_col ? '0 : c + 1'b1;
        n_row   = last_col ? (last_row ? '0 : r + 1'b1) : r;
        rd_addr = accept ? n_col : c;
    end

    always_comb begin
        o_op_push       = accept && (c != '0) && (r != '0);
        o_op.next_bit   = (r_ext >= 6'd2 && c_ext >= 6'd2) ? rule_cell : 1'b0;
        o_op.border     = last_col;
        o_op.flush      = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_window   <= '0;
            r_rd_valid <= 1'b0;
            r_rd_addr  <= '0;
        end else begin
            r_rd_valid <= 1'b1;
            r_rd_addr  <= rd_addr;
            if (accept) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_window <= n_window;
            end
        end
    end

    // write and fetch never hit the same column in one cycle
    always_ff @(posedge i_clk) begin
        if (accept) mem[c] <= {i_cell_in, r_rd[1]};
        r_rd <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cave_opq.sv
// Short queue of classified words between front and back end.
// Depends on cave_pkg (t_op, OPQ_DEPTH).
`default_nettype none
module cave_opq
    import cave_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    input  wire logic i_pop,
    output t_op       o_op,
    output logic      o_empty
);

    t_op              mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wr_ptr;
    logic [OPQ_AW-1:0] r_rd_ptr;
    logic [OPQ_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) mem[r_wr_ptr] <= i_op;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cave_back.sv
// Back end: expands each t_op into its result words and holds the output
// register. Depends on cave_pkg.
`default_nettype none
module cave_back
    import cave_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [CFG_SIZE_W-1:0] i_cols,
    input  wire t_op                   i_op,
    input  wire logic                  i_op_empty,
    output logic                       o_op_pop,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic                       o_cell_out,
    output logic                       o_last_of_run,
    output logic                       o_last_of_grid
);

    localparam logic [1:0] S_CELL   = 2'd0;
    localparam logic [1:0] S_BORDER = 2'd1;
    localparam logic [1:0] S_FLUSH  = 2'd2;

    logic                  r_cur_valid;
    t_op                   r_cur;
    logic [1:0]            r_stage;
    logic [CFG_SIZE_W-1:0] r_k;
    logic                  r_out_valid;
    logic                  r_cell;
    logic                  r_last_run;
    logic                  r_last_grid;

    logic out_free;
    logic emit;
    logic k_last;
    logic n_cell;
    logic n_last_run;
    logic n_last_grid;
    logic load;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_cur_valid && out_free;
    assign k_last   = (r_k == i_cols - 1'b1);

    always_comb begin
        n_cell      = 1'b0;
        n_last_grid = 1'b0;
        case (r_stage)
            S_CELL: begin
                n_cell     = r_cur.next_bit;
                n_last_run = !r_cur.border;
            end
            S_BORDER: begin
                n_last_run = !r_cur.flush;
            end
            S_FLUSH: begin
                n_last_run  = k_last;
                n_last_grid = k_last;
            end
            default: begin
                n_last_run = 1'b1;
            end
        endcase
    end

    assign load     = !r_cur_valid || (emit && n_last_run);
    assign o_op_pop = load && !i_op_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_stage     <= S_CELL;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= !i_op_empty;
                r_stage     <= S_CELL;
            end else if (emit) begin
                case (r_stage)
                    S_CELL:   r_stage <= S_BORDER;
                    S_BORDER: begin
                        r_stage <= S_FLUSH;
                        r_k     <= '0;
                    end
                    default:  r_k <= r_k + 1'b1;
                endcase
            end
            if (emit)       r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) r_cur <= i_op;
        if (emit) begin
            r_cell      <= n_cell;
            r_last_run  <= n_last_run;
            r_last_grid <= n_last_grid;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_cell_out     = r_cell;
    assign o_last_of_run  = r_last_run;
    assign o_last_of_grid = r_last_grid;

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for cave_cellular_automaton_step_core: directed and random raster grids,
// each result word checked against a next-generation predictor kept in this file.
// Depends on cave_pkg and the core RTL.
module tb;
    import cave_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400_000;

    typedef struct packed {
        logic cell_bit;
        logic run_end;
        logic grid_end;
    } gen_word_t;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  i_cell_in  = 1'b0;
    logic                  pop        = 1'b0;
    logic                  full;
    logic                  empty;
    logic                  o_cell_out;
    logic                  o_last_of_run;
    logic                  o_last_of_grid;

    // predictor copy of the registers and the grid state
    logic [CFG_SIZE_W-1:0] cfg_cols;
    logic [CFG_SIZE_W-1:0] cfg_rows;
    logic [CFG_THR_W-1:0]  cfg_keep;
    logic [CFG_THR_W-1:0]  cfg_floor;
    logic                  row_above2 [MAX_COLS_DEF];
    logic                  row_above1 [MAX_COLS_DEF];
    logic [8:0]            nbr_win;
    int unsigned           col_pos;
    int unsigned           row_pos;
    gen_word_t             next_gen_q [$];
    gen_word_t             exp_w;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cells_sent    = 0;
    int words_checked = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;

    cave_cellular_automaton_step_core i_dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .push,
        .full,
        .i_cell_in,
        .empty,
        .pop,
        .o_cell_out,
        .o_last_of_run,
        .o_last_of_grid
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cave_cellular_automaton_step_core: mismatch");
            $finish;
        end
    end

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic next_state(input logic [8:0] w);
        int walls;
        walls = 0;
        for (int i = 0; i < 9; i++)
            if (i != 4 && !w[i]) walls++;
        if (!w[4]) return (walls >= cfg_keep) ? 1'b0 : 1'b1;
        return (walls >= cfg_floor) ? 1'b0 : 1'b1;
    endfunction

    function automatic void add_word(input logic cell_bit, input logic grid_end);
        gen_word_t w;
        w.cell_bit = cell_bit;
        w.run_end  = 1'b0;
        w.grid_end = grid_end;
        next_gen_q.push_back(w);
    endfunction

    function automatic int unsigned cells_left();
        int unsigned cols;
        int unsigned rows;
        cols = fit_size(cfg_cols, MAX_COLS_DEF);
        rows = fit_size(cfg_rows, MAX_ROWS_DEF);
        if (col_pos >= cols || row_pos >= rows) return cols * rows;
        return cols * rows - (row_pos * cols + col_pos);
    endfunction

    // one accepted cell: update line stores and window, queue its results
    function automatic void predict_gen(input logic b);
        int unsigned cols;
        int unsigned rows;
        int unsigned n0;
        logic [2:0]  col_bits;
        gen_word_t   w;
        cols = fit_size(cfg_cols, MAX_COLS_DEF);
        rows = fit_size(cfg_rows, MAX_ROWS_DEF);
        n0 = next_gen_q.size();
        if (col_pos >= cols || row_pos >= rows) begin
            col_pos = 0;
            row_pos = 0;
        end
        col_bits = {b, row_above1[col_pos], row_above2[col_pos]};
        row_above2[col_pos] = row_above1[col_pos];
        row_above1[col_pos] = b;
        nbr_win = {col_bits, nbr_win[8:3]};
        if (row_pos >= 1 && col_pos >= 1)
            add_word((row_pos >= 2 && col_pos >= 2) ? next_state(nbr_win) : 1'b0, 1'b0);
        if (row_pos >= 1 && col_pos == cols - 1)
            add_word(1'b0, 1'b0);
        if (row_pos == rows - 1 && col_pos == cols - 1)
            for (int k = 0; k < cols; k++)
                add_word(1'b0, k == cols - 1);
        if (next_gen_q.size() > n0) begin
            w = next_gen_q.pop_back();
            w.run_end = 1'b1;
            next_gen_q.push_back(w);
        end
        col_pos++;
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
        end
    endfunction

    // result side: pop at random, or hold off for a requested stretch
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (next_gen_q.size() == 0) begin
                $error("result word with nothing expected: cell_out=%0b", o_cell_out);
                fail_count++;
            end else begin
                exp_w = next_gen_q.pop_front();
                words_checked++;
                if (o_cell_out !== exp_w.cell_bit) begin
                    $error("cell_out: expected %0b, got %0b", exp_w.cell_bit, o_cell_out);
                    fail_count++;
                end
                if (o_last_of_run !== exp_w.run_end) begin
                    $error("last_of_run: expected %0b, got %0b", exp_w.run_end,
                           o_last_of_run);
                    fail_count++;
                end
                if (o_last_of_grid !== exp_w.grid_end) begin
                    $error("last_of_grid: expected %0b, got %0b", exp_w.grid_end,
                           o_last_of_grid);
                    fail_count++;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cell(input logic b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_cell_in <= b;
        do @(posedge i_clk); while (full);
        predict_gen(b);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // stop sending and wait until every expected word is out, plus margin for
    // cells still in flight that produce no word
    task automatic drain_results();
        push <= 1'b0;
        while (next_gen_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            CFG_GRID_COLS:     cfg_cols  = val[CFG_SIZE_W-1:0];
            CFG_GRID_ROWS:     cfg_rows  = val[CFG_SIZE_W-1:0];
            CFG_WALL_KEEP:     cfg_keep  = val[CFG_THR_W-1:0];
            CFG_FLOOR_TO_WALL: cfg_floor = val[CFG_THR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] cols_v,
                               input logic [CFG_DATA_W-1:0] rows_v,
                               input logic [CFG_DATA_W-1:0] keep_v,
                               input logic [CFG_DATA_W-1:0] floor_v);
        drain_results();
        drive_reg(CFG_GRID_COLS, cols_v);
        drive_reg(CFG_GRID_ROWS, rows_v);
        drive_reg(CFG_WALL_KEEP, keep_v);
        drive_reg(CFG_FLOOR_TO_WALL, floor_v);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        if ($urandom_range(99) < 10) return CFG_DATA_W'($urandom_range(0, 2));
        return CFG_DATA_W'($urandom_range(3, 8));
    endfunction

    // thresholds mostly in the useful range; upper data bits are don't-care
    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(99) < 85) v = CFG_DATA_W'($urandom_range(0, 9));
        else v = CFG_DATA_W'($urandom_range(10, 15));
        if ($urandom_range(3) == 0) v[CFG_DATA_W-1:CFG_THR_W] = 2'($urandom_range(3));
        return v;
    endfunction

    // clamped sizes, thresholds past eight, resize that forces a restart, wrap
    task automatic test_directed_grids();
        logic [11:0] first_grid;
        logic [8:0]  walled_grid;
        first_grid  = 12'b1111_1101_1111;
        walled_grid = 9'b000_010_000;
        load_config(6'd4, 6'd2, 6'd9, 6'd15);
        for (int i = 0; i < 12; i++) send_cell(first_grid[i]);
        // three cells into the next grid leave the position at column 3
        repeat (3) send_cell(1'b0);
        load_config(6'd0, 6'd3, 6'd8, 6'd0);
        for (int i = 0; i < 9; i++) send_cell(walled_grid[i]);
    endtask

    task automatic test_random_grids(input int budget);
        int          sent0;
        int unsigned n;
        int unsigned density;
        sent0 = cells_sent;
        while (cells_sent - sent0 < budget) begin
            load_config(pick_size(), pick_size(), pick_threshold(), pick_threshold());
            density = $urandom_range(20, 80);
            n = cells_left();
            // some grids are cut short and left for the next setting
            if ($urandom_range(99) < 20) n = $urandom_range(1, n);
            repeat (n) send_cell($urandom_range(99) < density);
        end
    endtask

    task automatic test_extreme_sizes();
        int unsigned n;
        load_config(6'd63, 6'd2, 6'd0, 6'd9);
        // run past the end of the widest row, stopping two cells into the last row
        n = cells_left();
        if (n > 64) n = n - 60;
        repeat (n) send_cell($urandom_range(99) < 50);
        load_config(6'd3, 6'd62, 6'd5, 6'd4);
        repeat (12) send_cell($urandom_range(99) < 55);
        load_config(6'd62, 6'd63, 6'd4, 6'd5);
        repeat (10) send_cell($urandom_range(99) < 50);
    endtask

    // long pop hold-off while cells keep coming, so the input side stalls
    task automatic test_output_backpressure();
        int unsigned n;
        load_config(6'd6, 6'd4, 6'd3, 6'd5);
        n = cells_left() + 6;
        hold_req = 300;
        repeat (n) send_cell($urandom_range(99) < 50);
    endtask

    initial begin
        cfg_cols  = GRID_COLS_RST;
        cfg_rows  = GRID_ROWS_RST;
        cfg_keep  = WALL_KEEP_RST;
        cfg_floor = FLOOR_TO_WALL_RST;
        for (int i = 0; i < MAX_COLS_DEF; i++) begin
            row_above2[i] = 1'b0;
            row_above1[i] = 1'b0;
        end
        nbr_win = '0;
        col_pos = 0;
        row_pos = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 7;
        recv_idle_pct = 69;
        test_directed_grids();
        test_random_grids(25);

        send_idle_pct = 69;
        recv_idle_pct = 7;
        test_random_grids(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_extreme_sizes();

        drain_results();
        $display("%0d cells sent, %0d result words checked, %0d register writes",
                 cells_sent, words_checked, reg_writes);
        $display("small random grids, clamped sizes up to 62 wide, resize restarts, ",
                 "thresholds 0..15, idle sender and receiver, long output stall");
        if (fail_count == 0) begin
            $display("cave_cellular_automaton_step_core: match");
        end else begin
            $display("cave_cellular_automaton_step_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: cave_cellular_automaton_step_core.f
hw/rtl/cave_pkg.sv
hw/rtl/cave_front.sv
hw/rtl/cave_opq.sv
hw/rtl/cave_back.sv
hw/rtl/cave_cellular_automaton_step_core.sv
verif/tb.sv
